@@ src/ist_pkg.sv @@
`timescale 1ns / 1ps
// ist_pkg: operation codes and the cell control struct for integer_set_table.
// No dependencies; imported by ist_cell and integer_set_table.
package ist_pkg;

    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic cmp_en;     // register per-cell hit against the incoming key
        logic ins_en;     // write the latched key into the cell at the fill point
        logic rem_start;  // seed the removal token at the hit cell
        logic shift;      // move the token one cell up, copying keys down
    } t_cell_ctl;

endpackage

@@ src/integer_set_table.sv @@
`timescale 1ns / 1ps
// integer_set_table: set of distinct signed keys in insertion order, built as
// a chain of ist_cell entries. Depends on ist_pkg and ist_cell.
//
//  channel  | dir | tdata (low bit first)                      | tuser
//  ---------+-----+--------------------------------------------+--------------
//  s_axis   | in  | key[31:0]                                  | operation[1:0]
//  m_axis   | out | was_member, dropped_full, member_count[4:0] | -
//
// Query, insert, clear and a remove that misses: the accept edge registers one compare
// per cell, then the execute state forms the result and updates the chain.
// A remove that hits then closes the gap by a token walking up the chain one cell per
// cycle, one step per entry above the removed one (at least one); the chain goes idle
// once no cell holds the token.
// Reset (synchronous, active low) empties the set; keys are not cleared.
// A result waits in the output register; the next item is taken meanwhile,
// and only the result step stalls if the previous result is still unread.
module integer_set_table
    import ist_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key[31:0]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // was_member, dropped_full, member_count[4:0], pad
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    logic [7:0]        r_out_data, n_out_data;

    t_cell_ctl         w_ctl;
    logic [KEY_W-1:0]  w_keys [CAPACITY];
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_busy;
    logic [CAPACITY:0]   w_tok;   // w_tok[i] feeds cell i

    logic              w_accept;
    logic              w_out_free;
    logic              w_fire;
    logic              w_member;
    logic              w_full;
    logic              w_dropped;
    logic              w_insert;
    logic [CNT_W-1:0]  w_res_count;
    logic [CNT_W+4:0]  w_cnt_ext;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = (r_state == S_EXEC) && w_out_free;

    // per-cell hits are registered at accept; at most one is set
    assign w_full    = r_count == CNT_W'(CAPACITY);
    assign w_member  = (r_op != OP_CLEAR) && (|w_hit);
    assign w_insert  = (r_op == OP_INSERT) && !w_member && !w_full;
    assign w_dropped = (r_op == OP_INSERT) && !w_member && w_full;

    always_comb begin
        w_res_count = r_count;
        case (r_op)
            OP_CLEAR:  w_res_count = '0;
            OP_INSERT: if (w_insert) begin
                w_res_count = r_count + CNT_W'(1);
            end
            OP_REMOVE: if (w_member) begin
                w_res_count = r_count - CNT_W'(1);
            end
            default:   w_res_count = r_count;
        endcase
    end

    // member_count carries the low 5 bits of the count
    assign w_cnt_ext  = {5'b0, w_res_count};
    assign n_out_data = {1'b0, w_cnt_ext[CNT_OUT_W-1:0], w_dropped, w_member};

    always_comb begin
        w_ctl.cmp_en    = w_accept;
        w_ctl.ins_en    = w_fire && w_insert;
        w_ctl.rem_start = w_fire && (r_op == OP_REMOVE) && w_member;
        w_ctl.shift     = (r_state == S_SHIFT);
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: if (w_accept) begin
                n_state = S_EXEC;
            end
            S_EXEC: if (w_fire) begin
                if ((r_op == OP_REMOVE) && w_member) begin
                    n_state = S_SHIFT;      // count drops once the gap is closed
                end else begin
                    n_state = S_IDLE;
                    n_count = w_res_count;
                end
            end
            S_SHIFT: if (!(|w_busy)) begin
                n_state = S_IDLE;
                n_count = r_count - CNT_W'(1);
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(s_axis_tuser);
            r_key <= s_axis_tdata;
        end
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign w_tok[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_top
            assign w_next = w_keys[g];
        end else begin : g_mid
            assign w_next = w_keys[g+1];
        end

        ist_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_cmp_key  (s_axis_tdata),
            .i_wr_key   (r_key),
            .i_next_key (w_next),
            .i_tok      (w_tok[g]),
            .o_key      (w_keys[g]),
            .o_hit      (w_hit[g]),
            .o_tok_busy (w_busy[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ src/ist_cell.sv @@
`timescale 1ns / 1ps
// ist_cell: one entry of the key chain: key, compare hit and removal token.
// Depends on ist_pkg.
module ist_cell
    import ist_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [KEY_W-1:0]     i_cmp_key,
    input  logic [KEY_W-1:0]     i_wr_key,
    input  logic [KEY_W-1:0]     i_next_key,
    input  logic                 i_tok,
    output logic [KEY_W-1:0]     o_key,
    output logic                 o_hit,
    output logic                 o_tok_busy,
    output logic                 o_tok
);

    logic [KEY_W-1:0] r_key;
    logic             r_hit;
    logic             r_tok;
    logic             w_valid;
    logic             w_fill;
    logic             w_pass;

    assign w_valid = CNT_W'(IDX) < i_count;
    assign w_fill  = CNT_W'(IDX) == i_count;
    // token moves on only while a valid entry sits above the next cell
    assign w_pass  = (CNT_W+1)'(IDX + 2) < {1'b0, i_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            if (i_ctl.cmp_en) begin
                r_hit <= w_valid && (i_cmp_key == r_key);
            end
            if (i_ctl.rem_start) begin
                r_tok <= r_hit;
            end else if (i_ctl.shift) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en && w_fill) begin
            r_key <= i_wr_key;
        end else if (i_ctl.shift && r_tok) begin
            r_key <= i_next_key;
        end
    end

    assign o_key      = r_key;
    assign o_hit      = r_hit;
    assign o_tok_busy = r_tok;
    assign o_tok      = r_tok && w_pass;

endmodule
